// ===== sv/fbpa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the pool allocator.
package fbpa_pkg;

    localparam int DEF_POOL_SLOTS      = 8;
    localparam int DEF_BLOCKS_PER_POOL = 256;

    localparam int OPCODE_W   = 3;
    localparam int POOL_NUM_W = 4;
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 16;
    localparam int BLOCK_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int CREATED_W  = 3;
    localparam int OFFSET_W   = 24;
    localparam int RND_SIZE_W = 17;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = OPCODE_W + 1;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = STATUS_W;
    localparam int M_PAD_W   = M_TDATA_W - (CREATED_W + BLOCK_W + OFFSET_W + 2 * COUNT_W);

    // block sizes are rounded up to a multiple of eight bytes
    localparam logic [RND_SIZE_W-1:0] ALIGN_ADD = RND_SIZE_W'(7);

    localparam logic [OPCODE_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_ALLOC  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FREE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PARAM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RESOURCE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_POOL     = 2'd3;

    typedef struct packed {
        logic load_in;
        logic exec_done;
        logic create_init;
        logic fill_step;
        logic pop;
        logic resp_load;
    } dp_cmd_t;

    typedef struct packed {
        logic create_go;
        logic alloc_go;
        logic fill_last;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== sv/fixed_block_pool_allocator_top.sv =====
// Top level of the fixed-block pool allocator: controller, datapath and checks.
//
//  channel | dir | transfer fields
//  --------+-----+-----------------------------------------------------------
//  s_      | in  | tuser: opcode, block_given; tdata: pool_number, size_request,
//          |     |   count_request, block_number
//  m_      | out | tuser: status; tdata: created_pool, granted_block,
//          |     |   granted_offset, free_blocks, used_blocks
//
// Delete, free, query and rejected commands finish in the execute state; alloc adds
// a read state (the link RAM read is registered); create fills one link per cycle
// through the single write port of the link RAM, then loads its response.
// Reset clears the pool-taken mask and the control state; the link RAM is not
// cleared, every link is written by create or free before it is read.
// A result that has not been taken holds completion of the next command.
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int POOL_SLOTS      = DEF_POOL_SLOTS,
    parameter int BLOCKS_PER_POOL = DEF_BLOCKS_PER_POOL
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [3:0] pool_number, [19:4] size_request, [35:20] count_request,
    // [43:36] block_number, [47:44] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] opcode, [3] block_given
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] created_pool, [10:3] granted_block, [34:11] granted_offset,
    // [50:35] free_blocks, [66:51] used_blocks, [71:67] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [M_TUSER_W-1:0] m_tuser
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fbpa_datapath #(
        .POOL_SLOTS     (POOL_SLOTS),
        .BLOCKS_PER_POOL(BLOCKS_PER_POOL)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .sts     (sts)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous command still in progress");

    a_single_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("controller issued more than one datapath command");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec_done || cmd.pop || cmd.resp_load) |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_fill_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fill_step && sts.fill_last) |=> !cmd.fill_step)
        else $error("link fill ran past the block count");
`endif

endmodule

// ===== sv/fbpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/fbpa_ctrl.sv =====
// Controller state machine sequencing create, alloc and the commands finished in the execute state.
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_FILL = 5'b00100,
        ST_READ = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.create_go) begin
                    cmd.create_init = 1'b1;
                    state_next      = ST_FILL;
                end else if (sts.alloc_go) begin
                    // link read is issued this cycle
                    state_next = ST_READ;
                end else if (sts.out_free) begin
                    cmd.exec_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_READ: begin
                if (sts.out_free) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.resp_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/fbpa_datapath.sv =====
// Datapath: command register, pool tables, link RAM and result register.
module fbpa_datapath
    import fbpa_pkg::*;
#(
    parameter int POOL_SLOTS      = DEF_POOL_SLOTS,
    parameter int BLOCKS_PER_POOL = DEF_BLOCKS_PER_POOL
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts
);

    localparam int POOL_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LINK_W = $clog2(BLOCKS_PER_POOL + 1);
    localparam int DEPTH  = POOL_SLOTS * BLOCKS_PER_POOL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = LINK_W + RND_SIZE_W;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(BLOCKS_PER_POOL);

    function automatic logic [ADDR_W-1:0] link_addr(input logic [POOL_W-1:0] p,
                                                    input logic [LINK_W-1:0] i);
        return ADDR_W'(p) * ADDR_W'(BLOCKS_PER_POOL) + ADDR_W'(i);
    endfunction

    // held command fields
    logic [OPCODE_W-1:0]   op_reg;
    logic [POOL_NUM_W-1:0] pn_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  given_reg;
    logic [BLOCK_W-1:0]    blk_reg;

    // pool tables; entries are meaningful only while the pool is taken
    logic [POOL_SLOTS-1:0] taken_reg, taken_next;
    logic [RND_SIZE_W-1:0] size_tab_reg  [POOL_SLOTS];
    logic [LINK_W-1:0]     total_tab_reg [POOL_SLOTS];
    logic [COUNT_W-1:0]    free_tab_reg  [POOL_SLOTS];
    logic [LINK_W-1:0]     head_tab_reg  [POOL_SLOTS];

    logic [POOL_W-1:0] create_pool_reg;
    logic [LINK_W-1:0] fill_cnt_reg;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic [POOL_W-1:0]     pidx;
    logic                  pool_ok, taken, free_idx_ok, gate_ok;
    logic [LINK_W-1:0]     head;
    logic [RND_SIZE_W-1:0] cur_size, rounded;
    logic [LINK_W-1:0]     cur_total;
    logic [COUNT_W-1:0]    cur_free;
    logic                  any_free;
    logic [POOL_W-1:0]     new_pool;
    logic                  create_bad, create_big;
    logic [STATUS_W-1:0]   gate_status, simple_status;
    logic [COUNT_W-1:0]    q_free, q_used;
    logic                  do_delete, do_free;
    logic [COUNT_W:0]      fill_nxt;
    logic [PROD_W-1:0]     prod;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [LINK_W-1:0]     ram_wdata, ram_rdata;
    logic                  out_free, out_load;

    assign pidx        = POOL_W'(pn_reg);
    assign pool_ok     = int'(pn_reg) < POOL_SLOTS;
    assign taken       = pool_ok && taken_reg[pidx];
    assign head        = head_tab_reg[pidx];
    assign cur_size    = size_tab_reg[pidx];
    assign cur_total   = total_tab_reg[pidx];
    assign cur_free    = free_tab_reg[pidx];
    assign free_idx_ok = given_reg && (int'(blk_reg) < BLOCKS_PER_POOL);
    assign rounded     = (RND_SIZE_W'(size_reg) + ALIGN_ADD) & ~ALIGN_ADD;
    assign create_bad  = (size_reg == '0) || (count_reg == '0);
    assign create_big  = int'(count_reg) > BLOCKS_PER_POOL;

    // lowest pool slot not yet taken
    always_comb begin
        any_free = 1'b0;
        new_pool = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
            if (!taken_reg[i]) begin
                any_free = 1'b1;
                new_pool = POOL_W'(i);
            end
        end
    end

    assign gate_ok = taken && ((op_reg != OP_FREE) || free_idx_ok);

    always_comb begin
        if (!pool_ok) begin
            gate_status = ST_BAD_PARAM;
        end else if ((op_reg == OP_FREE) && !free_idx_ok) begin
            gate_status = ST_BAD_PARAM;
        end else begin
            gate_status = ST_NO_POOL;
        end
    end

    always_comb begin
        simple_status = ST_BAD_PARAM;
        do_delete     = 1'b0;
        do_free       = 1'b0;
        q_free        = '0;
        q_used        = '0;
        unique case (op_reg)
            OP_CREATE: begin
                simple_status = create_bad ? ST_BAD_PARAM : ST_NO_RESOURCE;
            end
            OP_DELETE: begin
                simple_status = gate_ok ? ST_OK : gate_status;
                do_delete     = gate_ok;
            end
            OP_ALLOC: begin
                // only reached here with an empty free list or a pool that is not taken
                simple_status = gate_ok ? ST_NO_RESOURCE : gate_status;
            end
            OP_FREE: begin
                simple_status = gate_ok ? ST_OK : gate_status;
                do_free       = gate_ok;
            end
            OP_QUERY: begin
                simple_status = gate_ok ? ST_OK : gate_status;
                if (gate_ok) begin
                    q_free = cur_free;
                    q_used = COUNT_W'(cur_total) - cur_free;
                end
            end
            default: begin
                simple_status = ST_BAD_PARAM;
            end
        endcase
    end

    assign fill_nxt = (COUNT_W + 1)'(fill_cnt_reg) + (COUNT_W + 1)'(1);
    assign prod     = PROD_W'(head) * PROD_W'(cur_size);

    assign sts.create_go = (op_reg == OP_CREATE) && !create_bad && !create_big && any_free;
    assign sts.alloc_go  = (op_reg == OP_ALLOC) && taken && (head != LINK_NULL);
    assign sts.fill_last = fill_nxt == (COUNT_W + 1)'(count_reg);
    assign sts.out_free  = out_free;

    // link RAM: fill chains the new pool, free pushes onto the head
    assign ram_we    = cmd.fill_step || (cmd.exec_done && do_free);
    assign ram_waddr = cmd.fill_step ? link_addr(create_pool_reg, fill_cnt_reg)
                                     : link_addr(pidx, LINK_W'(blk_reg));
    assign ram_wdata = cmd.fill_step
                     ? ((fill_nxt < (COUNT_W + 1)'(count_reg)) ? LINK_W'(fill_nxt) : LINK_NULL)
                     : head;
    assign ram_raddr = link_addr(pidx, head);

    fbpa_ram #(
        .WIDTH(LINK_W),
        .DEPTH(DEPTH)
    ) u_link_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        taken_next = taken_reg;
        if (cmd.create_init) begin
            taken_next[new_pool] = 1'b1;
        end
        if (cmd.exec_done && do_delete) begin
            taken_next[pidx] = 1'b0;
        end
    end

    // result register
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = cmd.exec_done || cmd.pop || cmd.resp_load;

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (cmd.exec_done) begin
            m_tdata_next = {{M_PAD_W{1'b0}}, q_used, q_free, {OFFSET_W{1'b0}},
                            {BLOCK_W{1'b0}}, {CREATED_W{1'b0}}};
            m_tuser_next = simple_status;
        end else if (cmd.pop) begin
            m_tdata_next = {{M_PAD_W{1'b0}}, {COUNT_W{1'b0}}, {COUNT_W{1'b0}},
                            OFFSET_W'(prod), BLOCK_W'(head), {CREATED_W{1'b0}}};
            m_tuser_next = ST_OK;
        end else if (cmd.resp_load) begin
            m_tdata_next = {{M_PAD_W{1'b0}}, {COUNT_W{1'b0}}, {COUNT_W{1'b0}},
                            {OFFSET_W{1'b0}}, {BLOCK_W{1'b0}}, CREATED_W'(create_pool_reg)};
            m_tuser_next = ST_OK;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            taken_reg    <= taken_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (cmd.load_in) begin
            op_reg    <= s_tuser[OPCODE_W-1:0];
            given_reg <= s_tuser[OPCODE_W];
            pn_reg    <= s_tdata[3:0];
            size_reg  <= s_tdata[19:4];
            count_reg <= s_tdata[35:20];
            blk_reg   <= s_tdata[43:36];
        end
        if (cmd.create_init) begin
            size_tab_reg[new_pool]  <= rounded;
            total_tab_reg[new_pool] <= LINK_W'(count_reg);
            free_tab_reg[new_pool]  <= count_reg;
            head_tab_reg[new_pool]  <= '0;
            create_pool_reg         <= new_pool;
            fill_cnt_reg            <= '0;
        end
        if (cmd.fill_step) begin
            fill_cnt_reg <= fill_cnt_reg + LINK_W'(1);
        end
        if (cmd.exec_done && do_free) begin
            head_tab_reg[pidx] <= LINK_W'(blk_reg);
            free_tab_reg[pidx] <= cur_free + COUNT_W'(1);
        end
        if (cmd.pop) begin
            head_tab_reg[pidx] <= ram_rdata;
            free_tab_reg[pidx] <= cur_free - COUNT_W'(1);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
